@@ hw/rtl/rhsv_pkg.sv @@
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared types and constants for the RGB to HSV pixel converter: the word
// that travels along the divider cell chain and its field widths.
// ----------------------------------------------------------------------------
package rhsv_pkg;

	localparam int PIX_W   = 8;            // channel and result width
	localparam int QUOT_W  = PIX_W;        // quotient bits, one per cell
	localparam int NUM_W   = 11;           // sector numerator k*d + e, below 6*255
	localparam int REM_W   = 17;           // 85 * numerator, below 2**17
	localparam int DIV_W   = 16;           // divisor aligned to the top quotient bit
	localparam int N_CELLS = QUOT_W;

	localparam logic [REM_W-1:0] HUE_SCALE = REM_W'(85);

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic [REM_W-1:0]  hue_rem;
		logic [DIV_W-1:0]  hue_div;
		logic [REM_W-1:0]  sat_rem;
		logic [DIV_W-1:0]  sat_div;
		logic [QUOT_W-1:0] hue_quo;
		logic [QUOT_W-1:0] sat_quo;
		pix_t              value;
	} div_word_t;

endpackage

@@ hw/rtl/rhsv_front.sv @@
// ----------------------------------------------------------------------------
// rhsv_front
// Two-stage front end: finds max, min and the hue sector, then builds the
// scaled numerators and aligned divisors for the divider chain.
// ----------------------------------------------------------------------------
module rhsv_front
	import rhsv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  pix_t      red,
	input  pix_t      green,
	input  pix_t      blue,
	output logic      out_valid,
	input  logic      out_ready,
	output div_word_t out_word
);

	logic             valid_s1, valid_s2;
	logic             ready_s1, ready_s2;
	pix_t             mx_s1, d_s1;
	logic [NUM_W-1:0] num_s1;
	div_word_t        word_s2;

	pix_t             mx, mn, d;
	logic             red_top, green_top;
	logic [NUM_W-1:0] r_x, g_x, b_x, d_x, num;
	div_word_t        word;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		d = mx - mn;
		red_top   = (red >= green) && (red >= blue);
		green_top = !red_top && (green >= blue);
		r_x = NUM_W'(red);
		g_x = NUM_W'(green);
		b_x = NUM_W'(blue);
		d_x = NUM_W'(d);
		if (red_top) begin
			if (green >= blue) num = g_x - b_x;
			else num = (d_x << 2) + (d_x << 1) + g_x - b_x;
		end else if (green_top) begin
			num = (d_x << 1) + b_x - r_x;
		end else begin
			num = (d_x << 2) + r_x - g_x;
		end
	end

	always_comb begin
		word.hue_quo = '0;
		word.sat_quo = '0;
		word.value   = mx_s1;
		if (d_s1 == '0) begin
			word.hue_rem = '0;
			word.sat_rem = '0;
			word.hue_div = {PIX_W'(1), PIX_W'(0)};
			word.sat_div = {PIX_W'(1), PIX_W'(0)};
		end else begin
			word.hue_rem = REM_W'(num_s1) * HUE_SCALE;
			word.sat_rem = REM_W'({d_s1, PIX_W'(0)}) - REM_W'(d_s1);
			word.hue_div = {d_s1, PIX_W'(0)};
			word.sat_div = {1'b0, mx_s1, 7'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			mx_s1  <= mx;
			d_s1   <= d;
			num_s1 <= num;
		end
		if (ready_s2 && valid_s1) word_s2 <= word;
	end

	assign out_valid = valid_s2;
	assign out_word  = word_s2;

endmodule

@@ hw/rtl/rhsv_cell.sv @@
// ----------------------------------------------------------------------------
// rhsv_cell
// One divider cell: resolves one quotient bit of both the hue and the
// saturation division by compare and subtract, then hands the word on.
// ----------------------------------------------------------------------------
module rhsv_cell
	import rhsv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_word_t in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output div_word_t out_word
);

	logic      valid_q;
	div_word_t word_q;
	div_word_t nxt;
	logic      hue_bit, sat_bit;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		nxt     = in_word;
		hue_bit = in_word.hue_rem >= REM_W'(in_word.hue_div);
		sat_bit = in_word.sat_rem >= REM_W'(in_word.sat_div);
		if (hue_bit) nxt.hue_rem = in_word.hue_rem - REM_W'(in_word.hue_div);
		if (sat_bit) nxt.sat_rem = in_word.sat_rem - REM_W'(in_word.sat_div);
		nxt.hue_div = in_word.hue_div >> 1;
		nxt.sat_div = in_word.sat_div >> 1;
		nxt.hue_quo = {in_word.hue_quo[QUOT_W-2:0], hue_bit};
		nxt.sat_quo = {in_word.sat_quo[QUOT_W-2:0], sat_bit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// advance the word only when a new one arrives
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) word_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

@@ hw/rtl/rgb_to_hsv_byte_pixel_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_byte_pixel_unit
// Converts one 8-bit RGB pixel to 8-bit hue, saturation and value.
// Pipeline: 2 front stages, then a chain of 8 divider cells,
// one quotient bit per cell.
// Throughput: one word per cycle; each stage stalls only on its successor.
// Reset: arst_n clears all valid flags asynchronously; payload is not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_byte_pixel_unit
	import rhsv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  pix_t red,
	input  pix_t green,
	input  pix_t blue,
	output logic out_valid,
	input  logic out_ready,
	output pix_t hue,
	output pix_t saturation,
	output pix_t value
);

	logic      chain_valid [N_CELLS+1];
	logic      chain_ready [N_CELLS+1];
	div_word_t chain_word  [N_CELLS+1];

	rhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_word  (chain_word[0])
	);

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		rhsv_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_word   (chain_word[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_word  (chain_word[i+1])
		);
	end

	assign out_valid              = chain_valid[N_CELLS];
	assign chain_ready[N_CELLS]   = out_ready;
	assign hue                    = chain_word[N_CELLS].hue_quo;
	assign saturation             = chain_word[N_CELLS].sat_quo;
	assign value                  = chain_word[N_CELLS].value;

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hue != 8'hff)
		else $error("hue reached 255");

	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturation == '0 |-> hue == '0)
		else $error("gray pixel with nonzero hue");

	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value == '0 |-> saturation == '0)
		else $error("black pixel with nonzero saturation");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while pipeline can drain");

endmodule
